>>> src/bvm_pkg.sv
// Package for the battery voltage monitor: widths, codes, reset values and the charge ladder.
`default_nettype none
package bvm_pkg;

    // Field widths
    localparam int MV_W    = 15;
    localparam int MA_W    = 13;
    localparam int DAY_W   = 5;
    localparam int MODE_W  = 2;
    localparam int PCT_W   = 7;
    localparam int ALPHA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // Item modes
    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_SET_MV = 2'd1,
        MODE_SET_MA = 2'd2
    } t_mode;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA    = 1'b0,
        CFG_CRITICAL = 1'b1
    } t_cfg_idx;

    // Smoothing weight limits, Q1.10
    localparam logic [ALPHA_W-1:0] ALPHA_MIN   = 11'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 11'd1024;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 11'd102;

    // Reset values
    localparam logic [MV_W-1:0]  CRITICAL_RESET = 15'd10500;
    localparam logic [MV_W-1:0]  VOLT_RESET     = 15'd12400;
    localparam logic [MV_W-1:0]  MIN_RESET      = 15'h7FFF;
    localparam logic [MV_W-1:0]  MAX_RESET      = 15'd0;
    localparam logic [DAY_W-1:0] DAY_RESET      = 5'd0;

    // Charge ladder thresholds, highest first, 10 percent apart
    localparam int LADDER_N = 9;
    localparam logic [MV_W-1:0] LADDER_MV [LADDER_N] = '{
        15'd12600, 15'd12400, 15'd12200, 15'd12000, 15'd11800,
        15'd11600, 15'd11400, 15'd11200, 15'd11000
    };

    // Map a voltage onto the percent ladder
    function automatic logic [PCT_W-1:0] percent_of(input logic [MV_W-1:0] mv);
        logic [PCT_W-1:0] pct;
        pct = 7'd10;
        for (int i = LADDER_N - 1; i >= 0; i--) begin
            if (mv >= LADDER_MV[i]) begin
                pct = PCT_W'(100 - 10 * i);
            end
        end
        return pct;
    endfunction

endpackage
`default_nettype wire

>>> src/bvm_in_if.sv
// Input channel of the battery voltage monitor: handshake and sample payload.
`default_nettype none
interface bvm_in_if
    import bvm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [MV_W-1:0]          voltage_mv;
    logic signed [MA_W-1:0]   sample_ma;
    logic [DAY_W-1:0]         day_of_month;
    logic                     sample_valid;

    modport source (
        output valid, mode, voltage_mv, sample_ma, day_of_month, sample_valid,
        input  ready
    );
    modport sink (
        input  valid, mode, voltage_mv, sample_ma, day_of_month, sample_valid,
        output ready
    );
endinterface
`default_nettype wire

>>> src/bvm_out_if.sv
// Result channel of the battery voltage monitor: handshake and status payload.
`default_nettype none
interface bvm_out_if
    import bvm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MV_W-1:0]          raw_mv;
    logic [MV_W-1:0]          smoothed_mv;
    logic signed [MA_W-1:0]   held_ma;
    logic [PCT_W-1:0]         charge_percent;
    logic                     is_critical;
    logic                     is_brownout;
    logic                     sensor_good;
    logic [MV_W-1:0]          day_min_mv;
    logic [MV_W-1:0]          day_max_mv;

    modport source (
        output valid, raw_mv, smoothed_mv, held_ma, charge_percent,
               is_critical, is_brownout, sensor_good, day_min_mv, day_max_mv,
        input  ready
    );
    modport sink (
        input  valid, raw_mv, smoothed_mv, held_ma, charge_percent,
               is_critical, is_brownout, sensor_good, day_min_mv, day_max_mv,
        output ready
    );
endinterface
`default_nettype wire

>>> src/battery_voltage_monitor.sv
// A result is registered and becomes valid in the cycle after its input transfer.
// Throughput: one item per cycle; the single result register refills in the
// cycle it is taken, so input ready drops only while an untaken result waits.
// The moving average uses one combinational 12x16 multiply-add per item.
// Reset (synchronous, active low) restores config, held state and result valid; result payload is not reset.
`default_nettype none
module battery_voltage_monitor
    import bvm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    bvm_in_if.sink                     i_in,
    bvm_out_if.source                  o_out
);

    // Configuration registers
    logic [ALPHA_W-1:0] r_alpha;
    logic [MV_W-1:0]    r_critical;

    // Held battery state
    logic [MV_W-1:0]        r_raw, n_raw;
    logic [MV_W-1:0]        r_avg, n_avg;
    logic signed [MA_W-1:0] r_ma, n_ma;
    logic                   r_sensor_ok, n_sensor_ok;
    logic [MV_W-1:0]        r_min, n_min;
    logic [MV_W-1:0]        r_max, n_max;
    logic [DAY_W-1:0]       r_day, n_day;

    // Result register
    logic                   r_out_valid;
    logic [MV_W-1:0]        r_o_raw, r_o_avg, r_o_min, r_o_max;
    logic signed [MA_W-1:0] r_o_ma;
    logic [PCT_W-1:0]       r_o_pct;
    logic                   r_o_crit, r_o_brown, r_o_good;

    logic               in_xfer;
    logic [ALPHA_W-1:0] cfg_alpha;
    logic signed [15:0] ema_delta;
    logic signed [27:0] ema_prod;
    logic signed [27:0] ema_step;
    logic signed [27:0] ema_sum;
    logic [MV_W-1:0]    day_min_base;
    logic [MV_W-1:0]    day_max_base;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Clamp the smoothing weight on write
    always_comb begin
        cfg_alpha = i_cfg_data[ALPHA_W-1:0];
        if (cfg_alpha < ALPHA_MIN) begin
            cfg_alpha = ALPHA_MIN;
        end else if (cfg_alpha > ALPHA_MAX) begin
            cfg_alpha = ALPHA_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= ALPHA_RESET;
            r_critical <= CRITICAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA:    r_alpha    <= cfg_alpha;
                CFG_CRITICAL: r_critical <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // Moving average as avg + round(alpha * (v - avg) / 1024)
    always_comb begin
        ema_delta = $signed({1'b0, i_in.voltage_mv}) - $signed({1'b0, r_avg});
        ema_prod  = $signed({1'b0, r_alpha}) * ema_delta;
        ema_step  = (ema_prod + 28'sd512) >>> 10;
        ema_sum   = $signed({13'b0, r_avg}) + ema_step;
    end

    // Restart the daily extremes on a new day
    assign day_min_base = (i_in.day_of_month != r_day) ? MIN_RESET : r_min;
    assign day_max_base = (i_in.day_of_month != r_day) ? MAX_RESET : r_max;

    // Next held state for the item at the input
    always_comb begin
        n_raw       = r_raw;
        n_avg       = r_avg;
        n_ma        = r_ma;
        n_sensor_ok = r_sensor_ok;
        n_min       = r_min;
        n_max       = r_max;
        n_day       = r_day;
        case (i_in.mode)
            MODE_SAMPLE: begin
                if (r_sensor_ok) begin
                    if (!i_in.sample_valid) begin
                        n_sensor_ok = 1'b0;
                    end else begin
                        n_raw = i_in.voltage_mv;
                        n_ma  = i_in.sample_ma;
                        n_avg = ema_sum[MV_W-1:0];
                        n_day = i_in.day_of_month;
                        n_min = (i_in.voltage_mv < day_min_base) ?
                                i_in.voltage_mv : day_min_base;
                        n_max = (i_in.voltage_mv > day_max_base) ?
                                i_in.voltage_mv : day_max_base;
                    end
                end
            end
            MODE_SET_MV: begin
                n_raw = i_in.voltage_mv;
                n_avg = i_in.voltage_mv;
            end
            MODE_SET_MA: begin
                n_ma = i_in.sample_ma;
            end
            default: ;
        endcase
    end

    // Advance held state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw       <= VOLT_RESET;
            r_avg       <= VOLT_RESET;
            r_ma        <= '0;
            r_sensor_ok <= 1'b1;
            r_min       <= MIN_RESET;
            r_max       <= MAX_RESET;
            r_day       <= DAY_RESET;
        end else if (in_xfer) begin
            r_raw       <= n_raw;
            r_avg       <= n_avg;
            r_ma        <= n_ma;
            r_sensor_ok <= n_sensor_ok;
            r_min       <= n_min;
            r_max       <= n_max;
            r_day       <= n_day;
        end
    end

    // Hold the result until its transfer; drop valid when taken and not refilled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_o_raw   <= n_raw;
            r_o_avg   <= n_avg;
            r_o_ma    <= n_ma;
            r_o_pct   <= percent_of(n_raw);
            r_o_crit  <= (n_raw < r_critical);
            r_o_brown <= (n_avg < r_critical);
            r_o_good  <= n_sensor_ok;
            r_o_min   <= n_min;
            r_o_max   <= n_max;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.raw_mv          = r_o_raw;
    assign o_out.smoothed_mv     = r_o_avg;
    assign o_out.held_ma         = r_o_ma;
    assign o_out.charge_percent  = r_o_pct;
    assign o_out.is_critical     = r_o_crit;
    assign o_out.is_brownout     = r_o_brown;
    assign o_out.sensor_good     = r_o_good;
    assign o_out.day_min_mv      = r_o_min;
    assign o_out.day_max_mv      = r_o_max;

    // Checks
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alpha >= ALPHA_MIN) && (r_alpha <= ALPHA_MAX))
        else $error("smoothing weight out of range");

    a_sensor_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sensor_ok |=> !r_sensor_ok)
        else $error("sensor flag recovered without reset");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_max != MAX_RESET) |-> (r_min <= r_max))
        else $error("daily minimum above daily maximum");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("transfer produced no result");

endmodule
`default_nettype wire
